/* rtl/signed_decimal_formatter_with_commas_core_assert.svh */
// Assertion macros shared by the formatter RTL.
`ifndef SIGNED_DECIMAL_FORMATTER_WITH_COMMAS_CORE_ASSERT_SVH
`define SIGNED_DECIMAL_FORMATTER_WITH_COMMAS_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SDFC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SDFC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sdfc_pkg.sv */
// Package: widths, character codes, sequencer states and helpers of the formatter.
package sdfc_pkg;

	localparam int VALUE_W        = 31;
	localparam int CHAR_W         = 8;
	localparam int LIM_W          = 64;
	localparam int MAX_DIGITS_DEF = 9;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CONV  = 5'b00010,
		ST_SIGN  = 5'b00100,
		ST_DIGIT = 5'b01000,
		ST_COMMA = 5'b10000
	} state_t;

	// largest magnitude with the given number of digits, elaboration only
	function automatic logic [LIM_W-1:0] max_mag(input int digits);
		logic [LIM_W-1:0] lim;
		lim = LIM_W'(1);
		for (int n = 0; n < digits; n++) begin
			lim = (lim << 3) + (lim << 1);
		end
		return lim - LIM_W'(1);
	endfunction

	function automatic logic [CHAR_W-1:0] to_ascii(input logic [3:0] d);
		return {4'h3, d};
	endfunction

endpackage

/* rtl/sdfc_in_if.sv */
// Input channel: one signed value per request.
interface sdfc_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sdfc_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

/* rtl/sdfc_out_if.sv */
// Output channel: one ASCII character per request, last marks the end of a number.
interface sdfc_out_if;
	logic                          valid;
	logic                          ready;
	logic [sdfc_pkg::CHAR_W-1:0]   character;
	logic                          last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

/* rtl/signed_decimal_formatter_with_commas_core.sv */
// Sequence: accept, shift-add-3 conversion of all VALUE_W (31) magnitude bits unless
// saturated, leading zero digits skipped, then one character per cycle (sign, digits,
// commas) as dout allows. The converter takes one magnitude bit a cycle, and a new number
// is accepted only in idle, once the last character of the previous one is loaded.
// The output register lets the last character wait while the next number is accepted.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and drops dout.valid.
`include "signed_decimal_formatter_with_commas_core_assert.svh"

module signed_decimal_formatter_with_commas_core #(
	parameter int MAX_DIGITS = sdfc_pkg::MAX_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	sdfc_in_if.sink           din,
	sdfc_out_if.source        dout
);

	localparam int VW     = sdfc_pkg::VALUE_W;
	localparam int BCD_W  = MAX_DIGITS * 4;
	localparam int CNT_W  = $clog2(VW);
	localparam int IDX_W  = $clog2(MAX_DIGITS);
	localparam logic [sdfc_pkg::LIM_W-1:0] LIM = sdfc_pkg::max_mag(MAX_DIGITS);
	localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(MAX_DIGITS - 1);
	localparam logic [1:0]       R_TOP   = 2'((MAX_DIGITS - 1) % 3);

	sdfc_pkg::state_t state_q;

	logic [VW-1:0]                 mag_q;
	logic [BCD_W-1:0]              bcd_q;
	logic                          neg_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [IDX_W-1:0]              idx_q;
	logic [1:0]                    r_q;
	logic                          started_q;
	logic                          out_valid_q;
	logic [sdfc_pkg::CHAR_W-1:0]   char_q;
	logic                          last_q;

	logic [VW-1:0]                 raw;
	logic                          neg_d;
	logic [VW-1:0]                 mag_d;
	logic                          sat_d;
	logic [BCD_W-1:0]              bcd_adj;
	logic [3:0]                    cur_digit;
	logic                          skip;
	logic                          adv;
	logic                          load;
	logic [sdfc_pkg::CHAR_W-1:0]   load_char;
	logic                          load_last;
	logic [1:0]                    r_dec;
	logic                          in_conv;
	logic                          out_digit;
	logic                          out_punct;

	assign din.ready      = (state_q == sdfc_pkg::ST_IDLE);
	assign dout.valid     = out_valid_q;
	assign dout.character = char_q;
	assign dout.last      = last_q;

	// magnitude and saturation check at accept
	assign raw   = unsigned'(din.value);
	assign neg_d = raw[VW-1];
	assign mag_d = neg_d ? VW'(~raw + VW'(1)) : raw;
	assign sat_d = {{(sdfc_pkg::LIM_W - VW){1'b0}}, mag_d} > LIM;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ?
				bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
		end
	end

	assign cur_digit = bcd_q[idx_q*4 +: 4];
	assign skip      = (state_q == sdfc_pkg::ST_DIGIT) && !started_q
		&& (cur_digit == 4'd0) && (idx_q != '0);
	assign adv       = !out_valid_q || dout.ready;
	assign r_dec     = (r_q == 2'd0) ? 2'd2 : r_q - 2'd1;

	always_comb begin
		load      = 1'b0;
		load_char = sdfc_pkg::CH_ZERO;
		load_last = 1'b0;
		case (state_q)
			sdfc_pkg::ST_SIGN: begin
				load      = adv;
				load_char = sdfc_pkg::CH_MINUS;
			end
			sdfc_pkg::ST_COMMA: begin
				load      = adv;
				load_char = sdfc_pkg::CH_COMMA;
			end
			sdfc_pkg::ST_DIGIT: begin
				load      = adv && !skip;
				load_char = sdfc_pkg::to_ascii(cur_digit);
				load_last = (idx_q == '0);
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sdfc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			r_q         <= '0;
			neg_q       <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= load;
			end
			case (state_q)
				sdfc_pkg::ST_IDLE: begin
					if (din.valid) begin
						neg_q     <= neg_d;
						cnt_q     <= '0;
						idx_q     <= IDX_TOP;
						r_q       <= R_TOP;
						started_q <= 1'b0;
						if (sat_d) begin
							state_q <= neg_d ? sdfc_pkg::ST_SIGN : sdfc_pkg::ST_DIGIT;
						end else begin
							state_q <= sdfc_pkg::ST_CONV;
						end
					end
				end
				sdfc_pkg::ST_CONV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(VW - 1)) begin
						state_q <= neg_q ? sdfc_pkg::ST_SIGN : sdfc_pkg::ST_DIGIT;
					end
				end
				sdfc_pkg::ST_SIGN: begin
					if (adv) begin
						state_q <= sdfc_pkg::ST_DIGIT;
					end
				end
				sdfc_pkg::ST_DIGIT: begin
					if (skip) begin
						idx_q <= idx_q - IDX_W'(1);
						r_q   <= r_dec;
					end else if (adv) begin
						started_q <= 1'b1;
						if (idx_q == '0) begin
							state_q <= sdfc_pkg::ST_IDLE;
						end else begin
							idx_q <= idx_q - IDX_W'(1);
							r_q   <= r_dec;
							if (r_q == 2'd0) begin
								state_q <= sdfc_pkg::ST_COMMA;
							end
						end
					end
				end
				sdfc_pkg::ST_COMMA: begin
					if (adv) begin
						state_q <= sdfc_pkg::ST_DIGIT;
					end
				end
				default: begin
					state_q <= sdfc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath: magnitude/BCD shift register and output character
	always_ff @(posedge clk) begin
		if ((state_q == sdfc_pkg::ST_IDLE) && din.valid) begin
			mag_q <= mag_d;
			bcd_q <= sat_d ? {MAX_DIGITS{4'h9}} : '0;
		end else if (state_q == sdfc_pkg::ST_CONV) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VW-1]};
			mag_q <= {mag_q[VW-2:0], 1'b0};
		end
		if (load) begin
			char_q <= load_char;
			last_q <= load_last;
		end
	end

	assign in_conv   = (state_q == sdfc_pkg::ST_CONV);
	assign out_digit = (dout.character >= sdfc_pkg::CH_ZERO)
		&& (dout.character <= sdfc_pkg::CH_NINE);
	assign out_punct = (dout.character == sdfc_pkg::CH_COMMA)
		|| (dout.character == sdfc_pkg::CH_MINUS);

	`SDFC_ASSERT_NXT(a_accept_starts, din.valid && din.ready, !din.ready, "accept did not start")
	`SDFC_ASSERT_IMP(a_conv_count, in_conv, cnt_q <= CNT_W'(VW - 1), "conversion counter overran")
	`SDFC_ASSERT_IMP(a_char_kind, dout.valid, out_digit || out_punct, "illegal character on dout")
	`SDFC_ASSERT_IMP(a_last_is_digit, dout.valid && dout.last, out_digit, "number ends on a non-digit")

endmodule

/* test/tb_signed_decimal_formatter_with_commas_core.sv */
// Testbench: checks the comma-grouped decimal text of each signed value against a scoreboard.
module tb_signed_decimal_formatter_with_commas_core;

	localparam int VALUE_W      = sdfc_pkg::VALUE_W;
	localparam int CHAR_W       = sdfc_pkg::CHAR_W;
	localparam int MAX_DIGITS   = sdfc_pkg::MAX_DIGITS_DEF;
	localparam int RANDOM_ITEMS = 160;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 64;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} glyph_t;

	// Expected text of every accepted request, oldest character first.
	class digit_stream_board;
		glyph_t pending_text[$];
		int     mismatches;

		function new();
			mismatches = 0;
		endfunction

		task report(string msg);
			if (mismatches < 100)
				$display("%0t: MISMATCH %s", $time, msg);
			mismatches++;
		endtask

		function int pending();
			return pending_text.size();
		endfunction

		function void note_number(logic signed [VALUE_W-1:0] v);
			logic [CHAR_W-1:0] rev [0:15];
			longint            mag;
			longint            limit;
			int                len;
			int                grp;
			bit                neg;
			glyph_t            g;
			neg   = v[VALUE_W-1];
			mag   = longint'(v);
			if (neg)
				mag = -mag;
			limit = 1;
			for (int n = 0; n < MAX_DIGITS; n++)
				limit = limit * 10;
			limit = limit - 1;
			if (mag > limit)
				mag = limit;
			len = 0;
			grp = 0;
			// built from the least significant digit upwards
			do begin
				if (grp == 3) begin
					rev[len] = sdfc_pkg::CH_COMMA;
					len++;
					grp = 0;
				end
				rev[len] = sdfc_pkg::CH_ZERO + CHAR_W'(mag % 10);
				len++;
				mag = mag / 10;
				grp++;
			end while (mag != 0);
			if (neg) begin
				rev[len] = sdfc_pkg::CH_MINUS;
				len++;
			end
			for (int k = len - 1; k >= 0; k--) begin
				g.character = rev[k];
				g.last      = (k == 0);
				pending_text.push_back(g);
			end
		endfunction

		task check_char(logic [CHAR_W-1:0] ch, logic last);
			glyph_t want;
			if (pending_text.size() == 0) begin
				report($sformatf("character %h with no request pending", ch));
			end else begin
				want = pending_text.pop_front();
				if (ch !== want.character)
					report($sformatf("character %h, wanted %h", ch, want.character));
				if (last !== want.last)
					report($sformatf("last %b on %h, wanted %b", last, ch, want.last));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   steady = 1'b0;
	bit   hold_req = 1'b0;

	digit_stream_board board = new();

	sdfc_in_if  din_ch();
	sdfc_out_if dout_ch();

	signed_decimal_formatter_with_commas_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		din_ch.valid  = 1'b0;
		din_ch.value  = '0;
		dout_ch.ready = 1'b0;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && din_ch.valid && din_ch.ready)
			board.note_number(din_ch.value);
		if (arst_n && dout_ch.valid && dout_ch.ready)
			board.check_char(dout_ch.character, dout_ch.last);
	end

	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, 8);
	endfunction

	task automatic send_number(logic signed [VALUE_W-1:0] v);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			@(negedge clk);
			din_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		din_ch.valid <= 1'b1;
		din_ch.value <= v;
		do @(posedge clk); while (!(din_ch.valid && din_ch.ready));
	endtask

	// receiver: random back-pressure, plus one long hold so the input stalls
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				@(negedge clk);
				dout_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end
			gap = draw_gap();
			if (gap > 0) begin
				@(negedge clk);
				dout_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			dout_ch.ready <= 1'b1;
			do @(posedge clk); while (!(dout_ch.valid && dout_ch.ready));
		end
	end

	initial begin
		int                         edge_values [] = '{
			0, 1, -1, 9, -9, 10, 99, 100, -100, 999, 1000, -1000, 12345, -123456,
			999999, 1000000, 999999999, -999999999, 1000000000, -1000000000,
			1073741823, -1073741824, 100000
		};
		int                         pick;
		int                         k;
		longint                     span;
		logic signed [VALUE_W-1:0] v;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (edge_values[i])
			send_number(VALUE_W'(edge_values[i]));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 40 && n < 70);
			if (n == 100)
				hold_req = 1'b1;
			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				// full 31-bit range, mostly within nine digits, some saturating
				v = VALUE_W'($urandom());
			end else if (pick < 9) begin
				k    = $urandom_range(1, MAX_DIGITS);
				span = 1;
				repeat (k) span = span * 10;
				v    = VALUE_W'(longint'($urandom()) % span);
				if ($urandom_range(0, 1))
					v = -v;
			end else begin
				v = VALUE_W'($urandom_range(0, 20)) - VALUE_W'(10);
			end
			send_number(v);
		end
		steady = 1'b0;

		@(negedge clk);
		din_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
